[rtl/mcd_pkg.sv]
// shared constants and types for the moravec corner detector
`default_nettype none

package mcd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int KERNEL_SPAN = 4;

  localparam int HALF   = KERNEL_SPAN / 2;
  localparam int WIN    = 2 * HALF + 1;
  localparam int LINES  = WIN - 1;
  localparam int LINE_W = LINES * 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int ROW_W   = 12;
  localparam int THR_W   = 18;
  localparam int SCORE_W = 18;
  localparam int XW      = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
  localparam int SQ_W    = 16;
  localparam int SUM_W   = SQ_W + $clog2(KERNEL_SPAN);
  localparam int SCORE_MAX = (1 << SCORE_W) - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = WIDTH_W'(640);
  localparam logic [ROW_W-1:0]   HEIGHT_RST = ROW_W'(480);
  localparam logic [THR_W-1:0]   THR_RST    = THR_W'(150000);

  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH      = 2'd0,
    CFG_IMAGE_HEIGHT     = 2'd1,
    CFG_CORNER_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    logic [ROW_W-1:0]   image_height;
    logic [THR_W-1:0]   corner_threshold;
  } cfg_t;

  typedef logic [WIN-1:0][7:0] pix_line_t;

  typedef struct packed {
    pix_line_t          hor;
    pix_line_t          ver;
    pix_line_t          dia;
    pix_line_t          anti;
    logic [COL_W-1:0]   center_x;
    logic [ROW_W-1:0]   center_y;
    logic               frame_last;
  } snap_t;

  typedef struct packed {
    logic               empty;
    logic [QCNT_W-1:0]  count;
  } q_stat_t;

  typedef struct packed {
    logic [COL_W-1:0]   center_x;
    logic [ROW_W-1:0]   center_y;
    logic [SCORE_W-1:0] score;
    logic               is_corner;
    logic               frame_last;
  } res_t;

endpackage

`default_nettype wire

[rtl/mcd_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/mcd_queue.sv]
// short queue of window snapshots between front and back
`default_nettype none

module mcd_queue import mcd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire snap_t   data_i,
  input  wire logic    pop_i,
  output snap_t        data_o,
  output q_stat_t      stat_o
);

  snap_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      tail_d = (tail_q == QPTR_W'(QDEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (pop_i) begin
      head_d = (head_q == QPTR_W'(QDEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[tail_q] <= data_i;
    end
  end

  assign data_o       = ent_q[head_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

`default_nettype wire

[rtl/mcd_front.sv]
// front: position tracking, line store, window and snapshot issue
`default_nettype none

module mcd_front import mcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] pixel_i,
  input  wire logic       frame_start_i,
  input  wire q_stat_t    q_stat_i,
  output logic            q_push_o,
  output snap_t           q_data_o
);

  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [COL_W-1:0]   col_q, col_d, c0, x;
  logic [ROW_W-1:0]   row_q, row_d, r0, y;
  logic               accept, has_res, is_last;
  logic [XW-1:0]      w_ext;

  logic               s1_valid_q, s1_has_q, s1_last_q, fwd_q, fwd_d;
  logic [7:0]         s1_px_q;
  logic [COL_W-1:0]   s1_x_q;
  logic [ROW_W-1:0]   s1_y_q;
  logic [LINE_W-1:0]  ram_rdata, fwd_data_q, wr_data;
  logic [LINES-1:0][7:0] lines, lines_wr;
  logic [WIN-1:0][7:0]   colv;
  logic [WIN-1:0][WIN-1:0][7:0] win_q, win_d;

  always_comb begin
    w_eff = cfg_i.image_width;
    if (w_eff < WIDTH_W'(WIN)) begin
      w_eff = WIDTH_W'(WIN);
    end else if (XW'(w_eff) > XW'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end
    h_eff = cfg_i.image_height;
    if (h_eff < ROW_W'(WIN)) begin
      h_eff = ROW_W'(WIN);
    end
  end

  assign w_ext  = XW'(w_eff);
  assign accept = push_i && !full_o;
  assign full_o = ((QCNT_W + 1)'(q_stat_i.count) + (QCNT_W + 1)'(s1_valid_q))
                  >= (QCNT_W + 1)'(QDEPTH);

  // position of the arriving pixel, with wrap after a shrunk size
  always_comb begin
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : row_q;
    x  = c0;
    y  = r0;
    if (XW'(c0) >= w_ext) begin
      x = '0;
      y = r0 + 1'b1;
    end
    if (y >= h_eff) begin
      y = '0;
    end
    has_res = (XW'(x) >= XW'(WIN - 1)) && (y >= ROW_W'(WIN - 1));
    is_last = (XW'(x) == w_ext - 1'b1) && (y == h_eff - 1'b1);
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (XW'(x) + 1'b1 >= w_ext) begin
        col_d = '0;
        row_d = ((ROW_W + 1)'(y) + 1'b1 >= (ROW_W + 1)'(h_eff)) ? '0 : y + 1'b1;
      end else begin
        col_d = x + 1'b1;
        row_d = y;
      end
    end
  end

  // a read of the column that is being written in the same cycle needs the fresh data
  assign fwd_d = accept && s1_valid_q && (x == s1_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      fwd_q      <= fwd_d;
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_x_q    <= x;
      s1_y_q    <= y;
      s1_has_q  <= has_res;
      s1_last_q <= is_last;
    end
    fwd_data_q <= wr_data;
  end

  mcd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_x_q),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (x),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    lines = fwd_q ? fwd_data_q : ram_rdata;
    for (int r = 0; r < LINES; r++) begin
      colv[r] = lines[r];
    end
    colv[LINES] = s1_px_q;
    for (int r = 0; r < LINES; r++) begin
      lines_wr[r] = colv[r + 1];
    end
    wr_data = lines_wr;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_d[r][c] = win_q[r][c + 1];
      end
      win_d[r][WIN - 1] = colv[r];
    end
  end

  always_comb begin
    for (int p = 0; p < WIN; p++) begin
      q_data_o.hor[p]  = win_d[HALF][p];
      q_data_o.ver[p]  = win_d[p][HALF];
      q_data_o.dia[p]  = win_d[p][p];
      q_data_o.anti[p] = win_d[p][WIN - 1 - p];
    end
    q_data_o.center_x   = s1_x_q - COL_W'(HALF);
    q_data_o.center_y   = s1_y_q - ROW_W'(HALF);
    q_data_o.frame_last = s1_last_q;
  end

  assign q_push_o = s1_valid_q && s1_has_q;

endmodule

`default_nettype wire

[rtl/mcd_back.sv]
// back: squared differences, directional sums, minimum and result queue
`default_nettype none

module mcd_back import mcd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [THR_W-1:0] threshold_i,
  input  wire q_stat_t          q_stat_i,
  input  wire snap_t            q_data_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output res_t                  res_o
);

  logic [3:0][WIN-1:0][7:0] dirs;
  logic [3:0][KERNEL_SPAN-1:0][SQ_W-1:0] sq_d, sq_q;
  logic [3:0][SUM_W-1:0] sum_d, sum_q;
  logic [COL_W-1:0]   b1_x_q, b2_x_q;
  logic [ROW_W-1:0]   b1_y_q, b2_y_q;
  logic               b1_last_q, b2_last_q;
  logic               b1_v_q, b2_v_q;
  logic [SUM_W-1:0]   min01, min23, min_all;
  logic [SCORE_W-1:0] score;
  res_t               push_word;
  logic [7:0]         ad;

  res_t               ent_q [ODEPTH];
  logic [OPTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [OCNT_W-1:0]  cnt_q, cnt_d;
  logic               opush, opop;

  assign q_pop_o = !q_stat_i.empty &&
                   (((OCNT_W + 1)'(cnt_q) + (OCNT_W + 1)'(b1_v_q) + (OCNT_W + 1)'(b2_v_q))
                    < (OCNT_W + 1)'(ODEPTH));

  always_comb begin
    dirs = {q_data_i.anti, q_data_i.dia, q_data_i.ver, q_data_i.hor};
    for (int d = 0; d < 4; d++) begin
      for (int k = 0; k < KERNEL_SPAN; k++) begin
        ad = (dirs[d][k] > dirs[d][k + 1]) ? dirs[d][k] - dirs[d][k + 1]
                                           : dirs[d][k + 1] - dirs[d][k];
        sq_d[d][k] = SQ_W'(ad) * SQ_W'(ad);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      sum_d[d] = '0;
      for (int k = 0; k < KERNEL_SPAN; k++) begin
        sum_d[d] = sum_d[d] + SUM_W'(sq_q[d][k]);
      end
    end
  end

  always_comb begin
    min01   = (sum_q[0] < sum_q[1]) ? sum_q[0] : sum_q[1];
    min23   = (sum_q[2] < sum_q[3]) ? sum_q[2] : sum_q[3];
    min_all = (min01 < min23) ? min01 : min23;
    if ((SUM_W + 1)'(min_all) > (SUM_W + 1)'(SCORE_MAX)) begin
      score = SCORE_W'(SCORE_MAX);
    end else begin
      score = SCORE_W'(min_all);
    end
    push_word.center_x   = b2_x_q;
    push_word.center_y   = b2_y_q;
    push_word.score      = score;
    push_word.is_corner  = (score > threshold_i);
    push_word.frame_last = b2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= q_pop_o;
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sq_q      <= sq_d;
      b1_x_q    <= q_data_i.center_x;
      b1_y_q    <= q_data_i.center_y;
      b1_last_q <= q_data_i.frame_last;
    end
    if (b1_v_q) begin
      sum_q     <= sum_d;
      b2_x_q    <= b1_x_q;
      b2_y_q    <= b1_y_q;
      b2_last_q <= b1_last_q;
    end
  end

  // result queue
  assign opush   = b2_v_q;
  assign empty_o = (cnt_q == '0);
  assign opop    = pop_i && !empty_o;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (opush) begin
      tail_d = (tail_q == OPTR_W'(ODEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (opop) begin
      head_d = (head_q == OPTR_W'(ODEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (opush && !opop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (opop && !opush) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ent_q[tail_q] <= push_word;
    end
  end

  assign res_o = ent_q[head_q];

endmodule

`default_nettype wire

[rtl/moravec_corner_detector.sv]
// top level of the streaming 5x5 moravec corner detector
//
//   channel   handshake           word
//   pixels    push / full         pixel_i, frame_start_i
//   results   empty / pop         center_x_o, center_y_o, score_o, is_corner_o, frame_last_o
//   config    cfg_we_i, no wait   cfg_idx_i, cfg_data_i
//
// one pixel per cycle while full is low; the line store ram is read and written once per pixel
// a result reaches the result ports from its taken pixel through the ram read, window
// update, squared differences, sums and minimum
// reset clears counters, window and queues; the line store needs no clearing
// full rises only when the snapshot queue is filled by a stalled back end, and the
// back end pauses only when the result queue has no room
`default_nettype none

module moravec_corner_detector import mcd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            pixel_i,
  input  wire logic                  frame_start_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [COL_W-1:0]           center_x_o,
  output logic [ROW_W-1:0]           center_y_o,
  output logic [SCORE_W-1:0]         score_o,
  output logic                       is_corner_o,
  output logic                       frame_last_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  snap_t   q_in, q_out;
  logic    q_push, q_pop;
  res_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= WIDTH_RST;
      cfg_q.image_height     <= HEIGHT_RST;
      cfg_q.corner_threshold <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:      cfg_q.image_width      <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:     cfg_q.image_height     <= cfg_data_i[ROW_W-1:0];
        CFG_CORNER_THRESHOLD: cfg_q.corner_threshold <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  mcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .data_o (q_out),
    .stat_o (q_stat)
  );

  mcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (cfg_q.corner_threshold),
    .q_stat_i    (q_stat),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign center_x_o   = res.center_x;
  assign center_y_o   = res.center_y;
  assign score_o      = res.score;
  assign is_corner_o  = res.is_corner;
  assign frame_last_o = res.frame_last;

endmodule

`default_nettype wire
